// ===== rtl/sbi_pkg.sv =====
package sbi_pkg;

  localparam int NUM_AXES = 3;

  // Per-axis classification carried from a lane to the merge stage
  typedef struct packed {
    logic parallel;
    logic outside;
  } slab_flags_t;

endpackage

// ===== rtl/sbi_lane.sv =====
module sbi_lane #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_WIDTH-1:0] start_c,
  input  logic signed [COORD_WIDTH-1:0] end_c,
  input  logic signed [COORD_WIDTH-1:0] box_min_c,
  input  logic signed [COORD_WIDTH-1:0] box_max_c,
  output sbi_pkg::slab_flags_t          flags,
  output logic signed [COORD_WIDTH+1:0] near_n,
  output logic signed [COORD_WIDTH+1:0] far_n,
  output logic        [COORD_WIDTH:0]   den
);
  import sbi_pkg::*;

  // Largest delta magnitude below the parallel threshold of 0.0001
  localparam int PAR_MAX = ((1 << FRAC_BITS) - 1) / 10000;

  logic signed [COORD_WIDTH:0]   d;
  logic signed [COORD_WIDTH:0]   n1;
  logic signed [COORD_WIDTH:0]   n2;
  logic signed [COORD_WIDTH+1:0] m1;
  logic signed [COORD_WIDTH+1:0] m2;
  logic        [COORD_WIDTH:0]   mag;

  // Form delta and slab numerators, flip signs so the denominator is positive
  always_comb begin
    d   = {end_c[COORD_WIDTH-1], end_c} - {start_c[COORD_WIDTH-1], start_c};
    n1  = {box_min_c[COORD_WIDTH-1], box_min_c} - {start_c[COORD_WIDTH-1], start_c};
    n2  = {box_max_c[COORD_WIDTH-1], box_max_c} - {start_c[COORD_WIDTH-1], start_c};
    mag = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : d;
    m1  = d[COORD_WIDTH] ? -{n1[COORD_WIDTH], n1} : {n1[COORD_WIDTH], n1};
    m2  = d[COORD_WIDTH] ? -{n2[COORD_WIDTH], n2} : {n2[COORD_WIDTH], n2};
  end

  // Register the parallel and outside flags, the ordered entry and exit numerators and the denominator
  always_ff @(posedge clk) begin
    if (en) begin
      flags.parallel <= (mag <= (COORD_WIDTH+1)'(PAR_MAX));
      flags.outside  <= (start_c < box_min_c) || (start_c > box_max_c);
      near_n         <= (m1 < m2) ? m1 : m2;
      far_n          <= (m1 < m2) ? m2 : m1;
      den            <= mag;
    end
  end

endmodule

// ===== rtl/sbi_merge.sv =====
module sbi_merge #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en2,
  input  logic                          en3,
  input  sbi_pkg::slab_flags_t          flags  [3],
  input  logic signed [COORD_WIDTH+1:0] near_n [3],
  input  logic signed [COORD_WIDTH+1:0] far_n  [3],
  input  logic        [COORD_WIDTH:0]   den    [3],
  output logic                          hit
);
  import sbi_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 4;

  logic [NUM_AXES-1:0] axis_ok;
  logic [NUM_AXES-1:0] par2;
  logic [NUM_AXES*NUM_AXES-1:0] pair_ok;

  // Single-axis checks against the unit interval
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        par2[i]    <= flags[i].parallel;
        axis_ok[i] <= flags[i].parallel ? !flags[i].outside :
                      ((near_n[i] <= $signed({1'b0, den[i]})) && (far_n[i] >= 0));
      end
    end
  end

  // Cross products: entry of axis i against exit of axis j
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_i
    for (genvar j = 0; j < NUM_AXES; j++) begin : g_j
      if (i != j) begin : g_pair
        logic signed [PW-1:0] lhs;
        logic signed [PW-1:0] rhs;
        always_ff @(posedge clk) begin
          if (en2) begin
            lhs <= PW'(near_n[i]) * PW'($signed({1'b0, den[j]}));
            rhs <= PW'(far_n[j]) * PW'($signed({1'b0, den[i]}));
          end
        end
        assign pair_ok[i*NUM_AXES+j] = par2[i] || par2[j] || (lhs <= rhs);
      end else begin : g_diag
        assign pair_ok[i*NUM_AXES+j] = 1'b1;
      end
    end
  end

  // Combine every check into the verdict
  always_ff @(posedge clk) begin
    if (en3) begin
      hit <= (&axis_ok) && (&pair_ok);
    end
  end

endmodule

// ===== rtl/segment_box_intersection_top.sv =====
// Channel  | Handshake                  | Payload
// in       | in_valid / in_stall        | start_*, end_*, box_min_*, box_max_*
// out      | out_valid / out_stall      | hit
//
// One item enters per cycle while in_stall is low; out_valid rises once the item has
// passed the lane register (loaded at the accepting edge), the product register and
// the output register.
// rst is synchronous and empties all three stages.
// A stalled output holds hit; stages behind it fill bubbles, and in_stall
// rises only once every stage holds an item.
module segment_box_intersection_top #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit
);
  import sbi_pkg::*;

  logic v1;
  logic v2;
  logic adv1;
  logic adv2;
  logic adv3;

  logic signed [COORD_WIDTH-1:0] s_c   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] e_c   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] lo_c  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi_c  [NUM_AXES];
  slab_flags_t                   flags [NUM_AXES];
  logic signed [COORD_WIDTH+1:0] near_n[NUM_AXES];
  logic signed [COORD_WIDTH+1:0] far_n [NUM_AXES];
  logic        [COORD_WIDTH:0]   den   [NUM_AXES];

  // Advance a stage when the one ahead is empty or moving
  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) out_valid <= v2;
    end
  end

  assign s_c  = '{start_x, start_y, start_z};
  assign e_c  = '{end_x, end_y, end_z};
  assign lo_c = '{box_min_x, box_min_y, box_min_z};
  assign hi_c = '{box_max_x, box_max_y, box_max_z};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    sbi_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (adv1),
      .start_c  (s_c[a]),
      .end_c    (e_c[a]),
      .box_min_c(lo_c[a]),
      .box_max_c(hi_c[a]),
      .flags    (flags[a]),
      .near_n   (near_n[a]),
      .far_n    (far_n[a]),
      .den      (den[a])
    );
  end

  sbi_merge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_merge (
    .clk   (clk),
    .en2   (adv2),
    .en3   (adv3),
    .flags (flags),
    .near_n(near_n),
    .far_n (far_n),
    .den   (den),
    .hit   (hit)
  );

endmodule

// ===== rtl/sbi_check.sv =====
module sbi_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("stalled result changed");

  // Drop all transactions on reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Stall input only when the whole pipeline is blocked
  a_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in pipeline");

  // Deliver an accepted transaction when out_stall stays low while it moves through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after latency");

endmodule

bind segment_box_intersection_top sbi_check u_sbi_check (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .hit      (hit)
);
